@@ hw/rtl/sdrd_pkg.sv @@
// Shared types and constants for the SD SPI block read parser.
package sdrd_pkg;

  localparam int BLOCK_LEN_W = 13;
  localparam int POLL_W      = 17;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 17;

  localparam logic [BLOCK_LEN_W-1:0] BLOCK_LEN_RST  = 13'd512;
  localparam logic [POLL_W-1:0]      POLL_LIMIT_RST = 17'h10000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POLL_LIMIT   = 2'd1;

  // card bytes
  localparam logic [7:0] R1_READY    = 8'h00;
  localparam logic [7:0] BUS_IDLE    = 8'hFF;
  localparam logic [7:0] TOKEN_START = 8'hFE;
  localparam int         R1_BUSY_BIT = 7;

  typedef enum logic [2:0] {
    PH_R1    = 3'd0,
    PH_TOKEN = 3'd1,
    PH_DATA  = 3'd2,
    PH_CRC1  = 3'd3,
    PH_CRC2  = 3'd4,
    PH_TRAIL = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SPI      = 3'd1,
    ST_R1_TIME  = 3'd2,
    ST_R1_BAD   = 3'd3,
    ST_TOK_TIME = 3'd4,
    ST_TOK_BAD  = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       rx_fault;
  } in_t;

  typedef struct packed {
    logic       is_status;
    logic [7:0] data_byte;
    logic [2:0] status;
  } out_t;

  typedef struct packed {
    logic [BLOCK_LEN_W-1:0] block_length;
    logic [POLL_W-1:0]      poll_limit;
  } cfg_t;

endpackage

@@ hw/rtl/sdrd_cfg.sv @@
// Configuration registers: block length and poll limit.
module sdrd_cfg import sdrd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg      = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_BLOCK_LENGTH: cfg_nxt.block_length = cfg_data[BLOCK_LEN_W-1:0];
        REG_POLL_LIMIT:   cfg_nxt.poll_limit   = cfg_data[POLL_W-1:0];
        default:          cfg_nxt = cfg_r;  // drop unknown indexes
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.block_length <= BLOCK_LEN_RST;
      cfg_r.poll_limit   <= POLL_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ hw/rtl/sdrd_core.sv @@
// Parse state machine: poll counter, data count and result decode for one word.
module sdrd_core import sdrd_pkg::*; #(
  parameter int MAX_BLOCK = 4096
) (
  input  logic clk,
  input  logic rst_n,
  input  logic item_go,
  input  in_t  item,
  input  cfg_t cfg,
  output logic res_valid,
  output out_t res
);

  localparam int BCW = $clog2(MAX_BLOCK + 1);
  localparam int CW  = (BCW > BLOCK_LEN_W) ? BCW : BLOCK_LEN_W;
  localparam logic [CW-1:0] MAXB = CW'(MAX_BLOCK);

  phase_t           phase_r, phase_nxt;
  logic [POLL_W-1:0] poll_count_r, poll_count_nxt;
  logic [BCW-1:0]   byte_count_r, byte_count_nxt;
  status_t          pend_r, pend_nxt;

  logic [POLL_W-1:0] poll_inc;
  logic              expired;
  logic [CW-1:0]     blen_ext;
  logic [CW-1:0]     eff_len;
  logic [BCW-1:0]    byte_inc;

  assign poll_inc = poll_count_r + 1'b1;
  // a zero limit acts as a limit of one
  assign expired  = (cfg.poll_limit == '0) ? (poll_inc != '0)
                                            : (poll_inc >= cfg.poll_limit);
  assign blen_ext = CW'(cfg.block_length);
  assign eff_len  = (blen_ext > MAXB) ? MAXB : blen_ext;
  assign byte_inc = byte_count_r + 1'b1;

  always_comb begin
    phase_nxt      = phase_r;
    poll_count_nxt = poll_count_r;
    byte_count_nxt = byte_count_r;
    pend_nxt       = pend_r;
    res_valid      = 1'b0;
    res            = '0;
    unique case (phase_r)
      PH_R1: begin
        poll_count_nxt = poll_inc;
        if (item.rx_fault) begin
          pend_nxt  = ST_SPI;
          phase_nxt = PH_TRAIL;
        end else if (expired) begin
          pend_nxt  = ST_R1_TIME;
          phase_nxt = PH_TRAIL;
        end else if (!item.rx_byte[R1_BUSY_BIT]) begin
          if (item.rx_byte == R1_READY) begin
            phase_nxt      = PH_TOKEN;
            poll_count_nxt = '0;
          end else begin
            pend_nxt  = ST_R1_BAD;
            phase_nxt = PH_TRAIL;
          end
        end
      end
      PH_TOKEN: begin
        poll_count_nxt = poll_inc;
        if (item.rx_fault) begin
          pend_nxt  = ST_SPI;
          phase_nxt = PH_TRAIL;
        end else if (expired) begin
          pend_nxt  = ST_TOK_TIME;
          phase_nxt = PH_TRAIL;
        end else if (item.rx_byte != BUS_IDLE) begin
          if (item.rx_byte == TOKEN_START) begin
            byte_count_nxt = '0;
            pend_nxt       = ST_OK;
            phase_nxt      = (eff_len == '0) ? PH_CRC1 : PH_DATA;
          end else begin
            pend_nxt  = ST_TOK_BAD;
            phase_nxt = PH_TRAIL;
          end
        end
      end
      PH_DATA: begin
        byte_count_nxt = byte_inc;
        if (CW'(byte_inc) >= eff_len) phase_nxt = PH_CRC1;
        res_valid     = 1'b1;
        res.data_byte = item.rx_byte;
      end
      PH_CRC1: phase_nxt = PH_CRC2;
      PH_CRC2: begin
        phase_nxt = PH_TRAIL;
        pend_nxt  = ST_OK;
      end
      PH_TRAIL: begin
        res_valid      = 1'b1;
        res.is_status  = 1'b1;
        res.status     = pend_r;
        phase_nxt      = PH_R1;
        poll_count_nxt = '0;
        byte_count_nxt = '0;
        pend_nxt       = ST_OK;
      end
      default: begin
        phase_nxt      = PH_R1;
        poll_count_nxt = '0;
        byte_count_nxt = '0;
        pend_nxt       = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_R1;
      poll_count_r <= '0;
      byte_count_r <= '0;
      pend_r       <= ST_OK;
    end else if (item_go) begin
      phase_r      <= phase_nxt;
      poll_count_r <= poll_count_nxt;
      byte_count_r <= byte_count_nxt;
      pend_r       <= pend_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(byte_count_r) <= MAXB)
    else $error("data count beyond maximum block");

  a_trail_clears: assert property (@(posedge clk) disable iff (!rst_n)
    item_go && phase_r == PH_TRAIL |=>
      phase_r == PH_R1 && poll_count_r == '0 && byte_count_r == '0 && pend_r == ST_OK)
    else $error("status word did not rearm the parser");

  a_data_exit: assert property (@(posedge clk) disable iff (!rst_n)
    item_go && phase_r == PH_DATA |=> phase_r == PH_DATA || phase_r == PH_CRC1)
    else $error("data phase left to a wrong phase");

endmodule

@@ hw/rtl/sd_spi_block_read_parser_top.sv @@
// Top level of the SD SPI-mode single block read parser.
// Usage:
//   in_*  : one word per byte clocked in from the card (rx_byte, rx_fault).
//   out_* : one word per data byte (is_status = 0) and one final status word
//           (is_status = 1) that ends each read.
//   cfg_* : register writes (index 0 block_length, 1 poll_limit), always
//           ready; write only while the parser is idle.
// Datapath: an accepted word is held in the input register, decoded by the
//   parse state machine, and its result lands in the output register that
//   drives out_valid. Throughput is one word per cycle, set by the single
//   decode step between the input and output registers, while no stall
//   holds the input register (see Stall).
// Stall: while out_ready is low and a result waits, a word that yields no
//   result still advances; the next result-bearing word holds in the input
//   register and in_ready drops until the output register frees.
// Reset: block_length 512, poll_limit 65536, parser waits for R1, both
//   registers empty.
module sd_spi_block_read_parser_top import sdrd_pkg::*; #(
  parameter int MAX_BLOCK = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;
  logic in_v_r;
  in_t  in_d_r;
  logic out_v_r, out_v_nxt;
  out_t out_d_r;
  logic advance;
  logic res_valid;
  out_t res;

  sdrd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sdrd_core #(.MAX_BLOCK(MAX_BLOCK)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_go   (advance),
    .item      (in_d_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  // advance the held word unless its result has nowhere to go
  assign advance  = in_v_r && (!res_valid || !out_v_r || out_ready);
  assign in_ready = !in_v_r || advance;

  always_comb begin
    out_v_nxt = out_v_r;
    if (advance && res_valid) out_v_nxt = 1'b1;
    else if (out_ready)       out_v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ready) in_v_r <= in_valid;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_d_r <= in_data;
    if (advance && res_valid) out_d_r <= res;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

endmodule

@@ bench/sdrd_read_checker.sv @@
// Checker for the SD SPI block read parser: tracks the parse, predicts and compares result words.
module sdrd_read_checker import sdrd_pkg::*; #(
  parameter int MAX_BLOCK = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_t                   in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_t                  out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_cnt,
  output int                    pending_cnt,
  output int                    data_cnt,
  output int                    status_cnt
);

  phase_t                 parse_ph;
  logic [POLL_W-1:0]      poll_n;
  logic [15:0]            passed_n;
  status_t                held_st;
  logic [BLOCK_LEN_W-1:0] len_reg;
  logic [POLL_W-1:0]      limit_reg;

  out_t card_words_due[$];
  int   errs;
  int   n_data;
  int   n_stat;

  function automatic logic [15:0] active_len();
    return (len_reg > MAX_BLOCK) ? 16'(MAX_BLOCK) : 16'(len_reg);
  endfunction

  // a zero limit behaves as a limit of one
  function automatic bit polls_used_up();
    return (limit_reg == '0) ? (poll_n >= 1) : (poll_n >= limit_reg);
  endfunction

  function automatic void end_read(input status_t code);
    held_st  = code;
    parse_ph = PH_TRAIL;
  endfunction

  function automatic void restart_read();
    parse_ph = PH_R1;
    poll_n   = '0;
    passed_n = '0;
    held_st  = ST_OK;
  endfunction

  function automatic bit parse_card_byte(input in_t w, output out_t r);
    bit got;
    got = 1'b0;
    r   = '0;
    case (parse_ph)
      PH_R1: begin
        poll_n = poll_n + 1'b1;
        if (w.rx_fault) end_read(ST_SPI);
        else if (polls_used_up()) end_read(ST_R1_TIME);
        else if (!w.rx_byte[R1_BUSY_BIT]) begin
          if (w.rx_byte == R1_READY) begin
            parse_ph = PH_TOKEN;
            poll_n   = '0;
          end else begin
            end_read(ST_R1_BAD);
          end
        end
      end
      PH_TOKEN: begin
        poll_n = poll_n + 1'b1;
        if (w.rx_fault) end_read(ST_SPI);
        else if (polls_used_up()) end_read(ST_TOK_TIME);
        else if (w.rx_byte != BUS_IDLE) begin
          if (w.rx_byte == TOKEN_START) begin
            passed_n = '0;
            held_st  = ST_OK;
            parse_ph = (active_len() == 0) ? PH_CRC1 : PH_DATA;
          end else begin
            end_read(ST_TOK_BAD);
          end
        end
      end
      PH_DATA: begin
        // faults are ignored once the token is in
        passed_n = passed_n + 1'b1;
        if (passed_n >= active_len()) parse_ph = PH_CRC1;
        r.data_byte = w.rx_byte;
        got = 1'b1;
      end
      PH_CRC1: parse_ph = PH_CRC2;
      PH_CRC2: begin
        parse_ph = PH_TRAIL;
        held_st  = ST_OK;
      end
      PH_TRAIL: begin
        r.is_status = 1'b1;
        r.status    = held_st;
        restart_read();
        got = 1'b1;
      end
      default: restart_read();
    endcase
    return got;
  endfunction

  always @(posedge clk) begin : watch
    out_t predicted;
    out_t due;
    if (!rst_n) begin
      restart_read();
      len_reg   = BLOCK_LEN_RST;
      limit_reg = POLL_LIMIT_RST;
      card_words_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (card_words_due.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("mismatch at %0t: unexpected word is_status=%0d data=%02h status=%0d",
                     $realtime, out_data.is_status, out_data.data_byte, out_data.status);
        end else begin
          due = card_words_due.pop_front();
          if (out_data.is_status !== due.is_status || out_data.data_byte !== due.data_byte ||
              out_data.status !== due.status) begin
            errs++;
            if (errs <= 10)
              $display("mismatch at %0t: expected is_status=%0d data=%02h status=%0d, %s%0d %s%02h %s%0d",
                       $realtime, due.is_status, due.data_byte, due.status,
                       "got is_status=", out_data.is_status, "data=", out_data.data_byte,
                       "status=", out_data.status);
          end
          if (due.is_status) n_stat++;
          else n_data++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BLOCK_LENGTH: len_reg = cfg_data[BLOCK_LEN_W-1:0];
          REG_POLL_LIMIT:   limit_reg = cfg_data[POLL_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (parse_card_byte(in_data, predicted)) card_words_due.push_back(predicted);
      end
    end
    fail_cnt    <= errs;
    pending_cnt <= card_words_due.size();
    data_cnt    <= n_data;
    status_cnt  <= n_stat;
  end

endmodule

@@ bench/sd_spi_block_read_parser_top_tb.sv @@
// Testbench top for the SD SPI block read parser: card byte stimulus, handshake idling, verdict.
module sd_spi_block_read_parser_top_tb;
  import sdrd_pkg::*;

  localparam int MAX_BLOCK   = 4096;
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 300;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int fail_cnt;
  int pending_cnt;
  int data_cnt;
  int status_cnt;

  int idle_pct = 0;
  int stall_pct = 0;
  int bytes_sent = 0;
  int cur_len = int'(BLOCK_LEN_RST);
  int cur_plim = int'(POLL_LIMIT_RST);
  int hold_req = 0;
  int hold_seen = 0;
  logic holding = 1'b0;
  int cycles = 0;

  sd_spi_block_read_parser_top #(.MAX_BLOCK(MAX_BLOCK)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  sdrd_read_checker #(.MAX_BLOCK(MAX_BLOCK)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_cnt(fail_cnt), .pending_cnt(pending_cnt), .data_cnt(data_cnt),
    .status_cnt(status_cnt)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= !holding && ($urandom_range(99) >= stall_pct);
  end

  // hold the result channel off for a long stretch on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        holding <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding <= 1'b0;
      end
    end
  end

  task automatic send(input logic [7:0] b, input logic f);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.rx_byte <= b;
    in_data.rx_fault <= f;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_any();
    send(8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  // leaves cfg_valid high so back-to-back writes need no extra step
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(input int len, input int plim);
    write_reg(REG_BLOCK_LENGTH, CFG_DATA_W'(len));
    write_reg(REG_POLL_LIMIT, CFG_DATA_W'(plim));
    cfg_valid <= 1'b0;
    @(posedge clk);
    cur_len = len;
    cur_plim = plim;
  endtask

  // wait until every due word is out, then let the input register drain
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one read, aligned with where the parser stops on a fault or timeout
  task automatic card_read(input int busy_n, input int wait_n, input logic [7:0] r1_val,
                           input logic [7:0] tok_val, input int fault_pct);
    int lim;
    int len;
    logic f;
    logic [7:0] b;
    lim = (cur_plim == 0) ? 1 : cur_plim;
    len = (cur_len > MAX_BLOCK) ? MAX_BLOCK : cur_len;
    for (int i = 0; i <= busy_n; i++) begin
      b = (i == busy_n) ? r1_val : 8'($urandom_range(128, 255));
      f = ($urandom_range(99) < fault_pct);
      send(b, f);
      if (f || i + 1 >= lim || (i == busy_n && r1_val != R1_READY)) begin
        send_any();
        return;
      end
    end
    for (int i = 0; i <= wait_n; i++) begin
      b = (i == wait_n) ? tok_val : BUS_IDLE;
      f = ($urandom_range(99) < fault_pct);
      send(b, f);
      if (f || i + 1 >= lim || (i == wait_n && tok_val != TOKEN_START)) begin
        send_any();
        return;
      end
    end
    repeat (len) send_any();
    repeat (3) send_any();
  endtask

  task automatic pick_config(input int max_len);
    int len;
    int plim;
    len = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, max_len);
    case ($urandom_range(7))
      0: plim = 0;
      1: plim = 1;
      2: plim = 2;
      3, 4: plim = 131071;
      default: plim = $urandom_range(3, 10);
    endcase
    set_config(len, plim);
  endtask

  task automatic random_reads(input int quota, input int max_len);
    int start;
    int kind;
    start = bytes_sent;
    while (bytes_sent - start < quota) begin
      if ($urandom_range(5) == 0) begin
        settle();
        pick_config(max_len);
      end
      kind = $urandom_range(99);
      if (kind < 5) repeat ($urandom_range(1, 4)) send_any();
      else if (kind < 12)
        card_read($urandom_range(4), $urandom_range(4), 8'($urandom_range(1, 127)),
                  TOKEN_START, 2);
      else if (kind < 19)
        card_read($urandom_range(4), $urandom_range(4), R1_READY,
                  8'($urandom_range(0, 253)), 2);
      else
        card_read($urandom_range(4), $urandom_range(4), R1_READY, TOKEN_START, 2);
    end
    settle();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // a full read with the registers as reset leaves them
    card_read(2, 2, R1_READY, TOKEN_START, 0);
    settle();

    // zero poll limit: the ready byte itself times out
    set_config(4, 0);
    send(R1_READY, 1'b0); send(8'hA5, 1'b1);
    settle();
    set_config(2, 2);
    // clean read; faults in data, CRC and trailer are ignored
    send(R1_READY, 1'b0); send(TOKEN_START, 1'b0); send(8'hFF, 1'b1); send(8'h00, 1'b0);
    send(8'h3C, 1'b1); send(8'hC3, 1'b0); send(8'h00, 1'b1);
    // R1 with busy bit clear but not zero
    send(8'h01, 1'b0); send(8'h5A, 1'b0);
    // token arrives on the limit poll: timeout wins
    send(R1_READY, 1'b0); send(BUS_IDLE, 1'b0); send(TOKEN_START, 1'b0); send(8'h81, 1'b1);
    // bad token
    send(R1_READY, 1'b0); send(8'h00, 1'b0); send(8'h7E, 1'b0);
    // fault on a good token ends the read
    send(R1_READY, 1'b0); send(TOKEN_START, 1'b1); send(BUS_IDLE, 1'b0);
    settle();
    // zero block length: CRC follows the token
    set_config(0, 2);
    send(R1_READY, 1'b0); send(TOKEN_START, 1'b0); send(8'h11, 1'b0); send(8'h22, 1'b0);
    send(8'h33, 1'b0);
    settle();
    write_reg(REG_SPARE_A, '1);
    write_reg(REG_SPARE_B, '0);
    cfg_valid <= 1'b0;
    @(posedge clk);
    // shrink the block length below the bytes already passed
    set_config(4, 2);
    send(R1_READY, 1'b0); send(TOKEN_START, 1'b0); send(8'h01, 1'b0); send(8'h80, 1'b0);
    send(8'hFE, 1'b0);
    settle();
    set_config(2, 2);
    send(8'h7F, 1'b1); send(8'hAA, 1'b0); send(8'h55, 1'b0); send(8'h99, 1'b0);
    settle();

    // oversized length keeps the data phase open; shrink it to close the read
    set_config(8191, 131071);
    send(R1_READY, 1'b0); send(TOKEN_START, 1'b0);
    repeat (24) send_any();
    settle();
    set_config(24, 131071);
    repeat (4) send_any();
    settle();

    // stall the result side while bytes keep coming
    set_config(48, 131071);
    hold_req <= hold_req + 1;
    card_read(0, 3, R1_READY, TOKEN_START, 0);
    settle();

    idle_pct = 0;
    stall_pct <= 0;
    random_reads(250, 24);
    idle_pct = 81;
    random_reads(250, 24);
    idle_pct = 0;
    stall_pct <= 81;
    random_reads(250, 24);
    idle_pct = 24;
    stall_pct <= 24;
    random_reads(250, 24);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Sent %0d card bytes; checked %0d data words and %0d read endings.",
             bytes_sent, data_cnt, status_cnt);
    $display("Blocks of 0 to 512 bytes plus an oversized length, poll limits 0 to 131071.");
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/sdrd_pkg.sv
hw/rtl/sdrd_cfg.sv
hw/rtl/sdrd_core.sv
hw/rtl/sd_spi_block_read_parser_top.sv
bench/sdrd_read_checker.sv
bench/sd_spi_block_read_parser_top_tb.sv
